// File: rtl/core/sof_pkg.sv
// ----------------------------------------------------------------------------
// sof_pkg: shared types and constants of the splat occlusion filter
// Beat formats, controller states and store constants.
// ----------------------------------------------------------------------------
package sof_pkg;

  // field widths
  localparam int ID_W     = 20;
  localparam int PIX_W    = 9;
  localparam int DEPTH_W  = 32;
  localparam int MARGIN_W = 7;

  // largest pixel coordinate an input beat can carry
  localparam int PIX_MAX = (1 << PIX_W) - 1;

  // default geometry
  localparam int SCREEN_WIDTH_DEF  = 512;
  localparam int SCREEN_HEIGHT_DEF = 512;
  localparam int RADIUS_DEF        = 6;

  // depth arithmetic
  localparam logic [DEPTH_W-1:0]  EMPTY_DEPTH  = '1;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 7'd2;
  localparam int                  PCT_SCALE    = 100;
  localparam int                  MULT_W       = 8;
  localparam int                  D100_W       = DEPTH_W + 7;
  localparam int                  PROD_W       = DEPTH_W + MULT_W;

  // command codes
  localparam logic CMD_SPLAT = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic               command;
    logic [ID_W-1:0]    point_id;
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
    logic [DEPTH_W-1:0] distance;
  } in_item_t;

  typedef struct packed {
    logic            [ID_W-1:0] point_id_res;
    logic            visible;
    logic            clear_done;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TEST,
    ST_TDRAIN,
    ST_SPLAT,
    ST_SDRAIN,
    ST_DONE
  } state_t;

endpackage

// File: rtl/core/splat_occlusion_filter_top.sv
// ----------------------------------------------------------------------------
// splat_occlusion_filter_top: depth-buffer occlusion test for projected points
// Tests each point against a depth store over its square neighborhood and
// splats the visible ones into the store.
//
//   channel  direction  handshake        beat
//   in_      input      valid / stall    in_item_t  (command, point, depth)
//   out_     output     valid / stall    out_item_t (id, visible, clear_done)
//   cfg_     input      valid / ready    margin_percent
//
// With S = (2*RADIUS+1)^2 cells per square and one store port per direction,
// every point's square of S cells is scanned through the read port, and a
// visible point's square is scanned a second time for the splat.
// A clear command sweeps the whole store, one cell a cycle.
// After reset the same sweep runs with in_stall high; configuration writes
// are taken throughout.
// A finished result waits in the output register; the next beat is accepted
// meanwhile, and only the following result waits on out_stall.
// ----------------------------------------------------------------------------
module splat_occlusion_filter_top #(
  parameter int SCREEN_WIDTH  = sof_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = sof_pkg::SCREEN_HEIGHT_DEF,
  parameter int RADIUS        = sof_pkg::RADIUS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  sof_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output sof_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sof_pkg::MARGIN_W-1:0]   cfg_data
);

  localparam int STORE_COLS  = SCREEN_WIDTH + 2 * RADIUS;
  localparam int STORE_ROWS  = SCREEN_HEIGHT + 2 * RADIUS;
  localparam int STORE_CELLS = STORE_COLS * STORE_ROWS;
  localparam int ADDR_W      = $clog2(STORE_CELLS);
  localparam int KW          = $clog2(2 * RADIUS + 1);
  localparam int CW          = $clog2(sof_pkg::PIX_MAX + 2 * RADIUS + 1);
  localparam int SC_W        = $clog2((STORE_COLS > STORE_ROWS ? STORE_COLS : STORE_ROWS) + 1);
  localparam int LIM_W       = (CW > SC_W) ? CW : SC_W;
  localparam logic [KW-1:0]     K_LAST     = KW'(2 * RADIUS);
  localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(STORE_CELLS - 1);

  // controller and datapath registers
  sof_pkg::state_t                state_r, state_nxt;
  logic                           clear_cmd_r, clear_cmd_nxt;
  logic [ADDR_W-1:0]              sweep_r, sweep_nxt;
  logic [sof_pkg::MARGIN_W-1:0]   margin_r;
  logic [sof_pkg::ID_W-1:0]       id_r, id_nxt;
  logic [sof_pkg::PIX_W-1:0]      px_r, px_nxt, py_r, py_nxt;
  logic [sof_pkg::DEPTH_W-1:0]    d_r, d_nxt;
  logic [sof_pkg::D100_W-1:0]     d100_r, d100_nxt;
  logic [sof_pkg::MULT_W-1:0]     mult_r, mult_nxt;
  logic [KW-1:0]                  kx_r, kx_nxt, ky_r, ky_nxt;
  logic [ADDR_W-1:0]              row_r, row_nxt, row_start_r, row_start_nxt;
  logic                           drain_r, drain_nxt;
  logic                           hidden_r, hidden_nxt;
  sof_pkg::out_item_t             out_r, out_nxt;
  logic                           out_valid_r, out_valid_nxt;

  // read pipeline
  logic                           s1_valid_r, s1_valid_nxt, s1_splat_r, s1_splat_nxt;
  logic [ADDR_W-1:0]              s1_addr_r, s1_addr_nxt;
  logic                           s2_valid_r, s2_valid_nxt;
  logic [sof_pkg::PROD_W-1:0]     prod_r, prod_nxt;
  logic [sof_pkg::DEPTH_W-1:0]    e_r, e_nxt;

  // memory port signals
  logic                           ram_we;
  logic [ADDR_W-1:0]              ram_waddr, ram_raddr;
  logic [sof_pkg::DEPTH_W-1:0]    ram_wdata, ram_rdata;

  logic                           in_acc, issue, cell_ok, k_last, occ;
  logic [LIM_W-1:0]               col_sum, row_sum;
  logic [ADDR_W-1:0]              base;

  sof_ram #(
    .WIDTH (sof_pkg::DEPTH_W),
    .DEPTH (STORE_CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != sof_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  // square cell position and bounds check
  assign col_sum = LIM_W'(px_r) + LIM_W'(kx_r);
  assign row_sum = LIM_W'(py_r) + LIM_W'(ky_r);
  assign cell_ok = (col_sum < LIM_W'(STORE_COLS)) && (row_sum < LIM_W'(STORE_ROWS));
  assign k_last  = (kx_r == K_LAST) && (ky_r == K_LAST);
  assign issue   = (state_r == sof_pkg::ST_TEST) || (state_r == sof_pkg::ST_SPLAT);

  // address of the square's top-left cell, kept modulo the address width
  assign base = ADDR_W'(ADDR_W'(in_data.pixel_y) * ADDR_W'(STORE_COLS))
              + ADDR_W'(in_data.pixel_x);

  // occlusion compare on the registered product
  assign occ = s2_valid_r && (e_r < d_r)
            && ({1'b0, d100_r} > prod_r);

  // read pipeline stages
  always_comb begin
    s1_valid_nxt = issue && cell_ok;
    s1_splat_nxt = (state_r == sof_pkg::ST_SPLAT);
    s1_addr_nxt  = row_r + ADDR_W'(kx_r);
    s2_valid_nxt = s1_valid_r && !s1_splat_r;
    prod_nxt     = sof_pkg::PROD_W'(mult_r) * sof_pkg::PROD_W'(ram_rdata);
    e_nxt        = ram_rdata;
  end

  // memory port: clear sweep, or min-write in the cycle after its read
  always_comb begin
    ram_raddr = row_r + ADDR_W'(kx_r);
    if (state_r == sof_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_r;
      ram_wdata = sof_pkg::EMPTY_DEPTH;
    end else begin
      ram_we    = s1_valid_r && s1_splat_r && (ram_rdata > d_r);
      ram_waddr = s1_addr_r;
      ram_wdata = d_r;
    end
  end

  // controller: next state and datapath updates
  always_comb begin
    state_nxt     = state_r;
    clear_cmd_nxt = clear_cmd_r;
    sweep_nxt     = sweep_r;
    id_nxt        = id_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    d_nxt         = d_r;
    d100_nxt      = d100_r;
    mult_nxt      = mult_r;
    kx_nxt        = kx_r;
    ky_nxt        = ky_r;
    row_nxt       = row_r;
    row_start_nxt = row_start_r;
    drain_nxt     = drain_r;
    hidden_nxt    = hidden_r | occ;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      sof_pkg::ST_CLEAR: begin
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == SWEEP_LAST) begin
          sweep_nxt = '0;
          state_nxt = clear_cmd_r ? sof_pkg::ST_DONE : sof_pkg::ST_IDLE;
        end
      end
      sof_pkg::ST_IDLE: begin
        if (in_acc) begin
          id_nxt        = in_data.point_id;
          px_nxt        = in_data.pixel_x;
          py_nxt        = in_data.pixel_y;
          d_nxt         = in_data.distance;
          d100_nxt      = sof_pkg::D100_W'(in_data.distance) * sof_pkg::D100_W'(sof_pkg::PCT_SCALE);
          mult_nxt      = sof_pkg::MULT_W'(sof_pkg::PCT_SCALE) + sof_pkg::MULT_W'(margin_r);
          kx_nxt        = '0;
          ky_nxt        = '0;
          row_nxt       = base;
          row_start_nxt = base;
          drain_nxt     = 1'b0;
          hidden_nxt    = 1'b0;
          if (in_data.command == sof_pkg::CMD_CLEAR) begin
            clear_cmd_nxt = 1'b1;
            sweep_nxt     = '0;
            state_nxt     = sof_pkg::ST_CLEAR;
          end else begin
            clear_cmd_nxt = 1'b0;
            state_nxt     = sof_pkg::ST_TEST;
          end
        end
      end
      sof_pkg::ST_TEST, sof_pkg::ST_SPLAT: begin
        // walk the square row by row, wrapping back to its corner
        if (k_last) begin
          kx_nxt    = '0;
          ky_nxt    = '0;
          row_nxt   = row_start_r;
          state_nxt = (state_r == sof_pkg::ST_TEST) ? sof_pkg::ST_TDRAIN : sof_pkg::ST_SDRAIN;
        end else if (kx_r == K_LAST) begin
          kx_nxt  = '0;
          ky_nxt  = ky_r + 1'b1;
          row_nxt = row_r + ADDR_W'(STORE_COLS);
        end else begin
          kx_nxt = kx_r + 1'b1;
        end
      end
      sof_pkg::ST_TDRAIN: begin
        // toggle drain_r and leave once the last compare has landed
        drain_nxt = !drain_r;
        if (drain_r) begin
          state_nxt = (hidden_r | occ) ? sof_pkg::ST_DONE : sof_pkg::ST_SPLAT;
        end
      end
      sof_pkg::ST_SDRAIN: begin
        state_nxt = sof_pkg::ST_DONE;
      end
      sof_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (clear_cmd_r) begin
            out_nxt.point_id_res = '0;
            out_nxt.visible      = 1'b0;
            out_nxt.clear_done   = 1'b1;
          end else begin
            out_nxt.point_id_res = id_r;
            out_nxt.visible      = !hidden_r;
            out_nxt.clear_done   = 1'b0;
          end
          state_nxt = sof_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sof_pkg::ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sof_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_cmd_r <= 1'b0;
      sweep_r     <= '0;
      margin_r    <= sof_pkg::MARGIN_RESET;
      drain_r     <= 1'b0;
      out_valid_r <= 1'b0;
      s1_valid_r  <= 1'b0;
      s1_splat_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      kx_r        <= '0;
      ky_r        <= '0;
    end else begin
      clear_cmd_r <= clear_cmd_nxt;
      sweep_r     <= sweep_nxt;
      if (cfg_valid && cfg_ready) begin
        margin_r <= cfg_data;
      end
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
      s1_valid_r  <= s1_valid_nxt;
      s1_splat_r  <= s1_splat_nxt;
      s2_valid_r  <= s2_valid_nxt;
      kx_r        <= kx_nxt;
      ky_r        <= ky_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    id_r        <= id_nxt;
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    d_r         <= d_nxt;
    d100_r      <= d100_nxt;
    mult_r      <= mult_nxt;
    row_r       <= row_nxt;
    row_start_r <= row_start_nxt;
    hidden_r    <= hidden_nxt;
    out_r       <= out_nxt;
    s1_addr_r   <= s1_addr_nxt;
    prod_r      <= prod_nxt;
    e_r         <= e_nxt;
  end

  // no store write while the test scan reads
  a_no_write_in_test: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sof_pkg::ST_TEST) |-> !ram_we)
    else $error("store written during occlusion test");

  // all splat writes have landed before the result is posted
  a_no_write_in_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sof_pkg::ST_DONE) |-> !ram_we)
    else $error("store write still pending at result");

  // a new beat only enters with the read pipeline empty
  a_pipe_empty_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (!s1_valid_r && !s2_valid_r))
    else $error("beat accepted with reads in flight");

  // a clear acknowledgment never reports a visible point
  a_clear_not_visible: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.visible && out_r.clear_done))
    else $error("clear result flagged visible");

endmodule

// File: rtl/core/sof_ram.sv
// ----------------------------------------------------------------------------
// sof_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sof_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: verif/splat_occlusion_filter_top_test.sv
// ----------------------------------------------------------------------------
// splat_occlusion_filter_top_test: self-checking bench of the occlusion filter
// Drives points and clear commands into the filter, keeps its own copy of the
// depth store to predict each visible flag, and compares every result beat in
// order. Runs directed corner cases, clustered near-to-far streams at several
// margin settings, random idling on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module splat_occlusion_filter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // geometry of the default build
  localparam int SCREEN_W   = sof_pkg::SCREEN_WIDTH_DEF;
  localparam int SCREEN_H   = sof_pkg::SCREEN_HEIGHT_DEF;
  localparam int RAD        = sof_pkg::RADIUS_DEF;
  localparam int STORE_COLS = SCREEN_W + 2 * RAD;
  localparam int STORE_ROWS = SCREEN_H + 2 * RAD;
  localparam int MAP_CELLS  = STORE_COLS * STORE_ROWS;
  localparam int SIDE       = 2 * RAD + 1;

  // run control
  localparam int          CLUSTER_SPAN    = 24;
  localparam int          HOLD_OFF_CYCLES = 3000;
  localparam int          END_WAIT_CYCLES = 700;
  localparam int unsigned WATCHDOG_LIMIT  = 1_100_000;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  sof_pkg::in_item_t            in_data;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  sof_pkg::out_item_t           out_data;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [sof_pkg::MARGIN_W-1:0] cfg_data;

  // predictor state
  logic [sof_pkg::DEPTH_W-1:0]  depth_map [MAP_CELLS];
  logic [sof_pkg::MARGIN_W-1:0] margin_pct;
  sof_pkg::out_item_t           pending_results [$];

  // stimulus state
  logic [sof_pkg::PIX_W-1:0]    cluster_x;
  logic [sof_pkg::PIX_W-1:0]    cluster_y;
  logic [sof_pkg::DEPTH_W-1:0]  cluster_depth;
  int                           cluster_left = 0;
  bit                           send_idle_on = 1'b1;
  bit                           recv_idle_on = 1'b1;
  int                           hold_cycles = 0;
  int                           stall_left = 0;
  int                           error_count = 0;
  int unsigned                  quiet_cycles = 0;

  splat_occlusion_filter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10ns clk = ~clk;

  // ---------------------------------------------------------------------------
  // depth store prediction
  // ---------------------------------------------------------------------------

  function automatic void empty_depth_map();
    foreach (depth_map[i]) depth_map[i] = sof_pkg::EMPTY_DEPTH;
  endfunction

  // a stored depth hides the point when nearer by more than the margin
  function automatic bit is_occluder(logic [sof_pkg::DEPTH_W-1:0] stored,
                                     logic [sof_pkg::DEPTH_W-1:0] pt_depth);
    logic [63:0] far_scaled;
    logic [63:0] near_scaled;
    far_scaled  = 64'(sof_pkg::PCT_SCALE) * 64'(pt_depth);
    near_scaled = (64'(sof_pkg::PCT_SCALE) + 64'(margin_pct)) * 64'(stored);
    return (stored < pt_depth) && (far_scaled > near_scaled);
  endfunction

  // test the square around the point, splat it when visible, queue the result
  function automatic void predict_visibility(sof_pkg::in_item_t it);
    sof_pkg::out_item_t res;
    bit                 hidden;
    int                 kx;
    int                 ky;
    int                 col;
    int                 row;
    int                 idx;
    res = '0;
    if (it.command == sof_pkg::CMD_CLEAR) begin
      empty_depth_map();
      res.clear_done = 1'b1;
    end else begin
      hidden = 1'b0;
      for (ky = 0; ky < SIDE; ky++) begin
        for (kx = 0; kx < SIDE; kx++) begin
          col = int'(it.pixel_x) + kx;
          row = int'(it.pixel_y) + ky;
          if (col < STORE_COLS && row < STORE_ROWS) begin
            idx = row * STORE_COLS + col;
            if (is_occluder(depth_map[idx], it.distance)) hidden = 1'b1;
          end
        end
      end
      if (!hidden) begin
        for (ky = 0; ky < SIDE; ky++) begin
          for (kx = 0; kx < SIDE; kx++) begin
            col = int'(it.pixel_x) + kx;
            row = int'(it.pixel_y) + ky;
            if (col < STORE_COLS && row < STORE_ROWS) begin
              idx = row * STORE_COLS + col;
              if (depth_map[idx] > it.distance) depth_map[idx] = it.distance;
            end
          end
        end
      end
      res.point_id_res = it.point_id;
      res.visible      = !hidden;
    end
    pending_results.insert(pending_results.size(), res);
  endfunction

  // ---------------------------------------------------------------------------
  // beat construction
  // ---------------------------------------------------------------------------

  function automatic sof_pkg::in_item_t make_point(logic [sof_pkg::ID_W-1:0]    pid,
                                                   logic [sof_pkg::PIX_W-1:0]   px,
                                                   logic [sof_pkg::PIX_W-1:0]   py,
                                                   logic [sof_pkg::DEPTH_W-1:0] pt_depth);
    sof_pkg::in_item_t it;
    it.command  = sof_pkg::CMD_SPLAT;
    it.point_id = pid;
    it.pixel_x  = px;
    it.pixel_y  = py;
    it.distance = pt_depth;
    return it;
  endfunction

  // mostly near-to-far points packed in a small window, plus strays
  function automatic sof_pkg::in_item_t next_point();
    sof_pkg::in_item_t           it;
    int unsigned                 pick;
    logic [sof_pkg::DEPTH_W-1:0] step;
    if (cluster_left == 0 || cluster_depth > 32'hE000_0000) begin
      cluster_x     = sof_pkg::PIX_W'($urandom_range(0, sof_pkg::PIX_MAX - CLUSTER_SPAN));
      cluster_y     = sof_pkg::PIX_W'($urandom_range(0, sof_pkg::PIX_MAX - CLUSTER_SPAN));
      cluster_depth = $urandom_range(32'h0001_0000, 32'h0400_0000);
      cluster_left  = $urandom_range(10, 40);
    end
    cluster_left--;
    pick = $urandom_range(0, 99);
    it = make_point(sof_pkg::ID_W'($urandom_range(0, (1 << sof_pkg::ID_W) - 1)),
                    sof_pkg::PIX_W'(cluster_x + $urandom_range(0, CLUSTER_SPAN)),
                    sof_pkg::PIX_W'(cluster_y + $urandom_range(0, CLUSTER_SPAN)),
                    cluster_depth);
    if (pick < 80) begin
      // step a little farther away, small steps often within the margin
      step = (pick < 40) ? (cluster_depth >> 7) : (cluster_depth >> 4);
      cluster_depth = cluster_depth + $urandom_range(0, step);
      it.distance = cluster_depth;
    end else if (pick < 90) begin
      // stray point anywhere with any depth
      it.pixel_x  = sof_pkg::PIX_W'($urandom_range(0, sof_pkg::PIX_MAX));
      it.pixel_y  = sof_pkg::PIX_W'($urandom_range(0, sof_pkg::PIX_MAX));
      it.distance = $urandom();
    end else if (pick < 92) begin
      // depth extremes at a random spot
      it.pixel_x  = sof_pkg::PIX_W'($urandom_range(0, sof_pkg::PIX_MAX));
      it.pixel_y  = sof_pkg::PIX_W'($urandom_range(0, sof_pkg::PIX_MAX));
      it.distance = $urandom_range(0, 1) ? sof_pkg::EMPTY_DEPTH : '0;
    end else begin
      // out of order: nearer than the points before it
      it.distance = cluster_depth - $urandom_range(0, cluster_depth >> 3);
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // offer one beat on the input channel and predict it once taken
  task automatic send_beat(input sof_pkg::in_item_t it);
    int gap;
    gap = send_idle_on ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  = it;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_visibility(it);
  endtask

  task automatic settle_inputs();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // sender pauses until every result is back
  task automatic wait_idle();
    settle_inputs();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_margin(input logic [sof_pkg::MARGIN_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    margin_pct = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_stream(input int count);
    repeat (count) send_beat(next_point());
  endtask

  // result side stall: long hold-off first, else the per-beat draw
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall = 1'b1;
    end else begin
      out_stall = (stall_left > 0);
      if (out_valid && stall_left > 0) stall_left--;
    end
  end

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // compare each result beat against the oldest prediction
  always @(posedge clk) begin
    sof_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with none pending, id %0h",
                                  out_data.point_id_res));
      end else begin
        want = pending_results.pop_front();
        if (out_data.point_id_res !== want.point_id_res)
          report_mismatch($sformatf("point_id_res %0h, want %0h",
                                    out_data.point_id_res, want.point_id_res));
        if (out_data.visible !== want.visible)
          report_mismatch($sformatf("visible %0b, want %0b for id %0h",
                                    out_data.visible, want.visible, want.point_id_res));
        if (out_data.clear_done !== want.clear_done)
          report_mismatch($sformatf("clear_done %0b, want %0b for id %0h",
                                    out_data.clear_done, want.clear_done, want.point_id_res));
      end
      stall_left = recv_idle_on ? $urandom_range(0, 5) : 0;
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // screen corners, depth extremes, zero depth, id and pixel bit patterns
  task automatic test_corner_cases();
    send_beat(make_point(20'h00000, 9'd0, 9'd0, 32'h0001_0000));
    send_beat(make_point(20'hFFFFF, 9'd0, 9'd0, 32'h0001_0280));  // inside margin
    send_beat(make_point(20'h00001, 9'd0, 9'd0, 32'h0001_1000));  // beyond margin
    send_beat(make_point(20'h55555, 9'd511, 9'd511, sof_pkg::EMPTY_DEPTH));
    send_beat(make_point(20'hAAAAA, 9'd511, 9'd511, 32'hFFFF_FFFE));
    send_beat(make_point(20'h12345, 9'd511, 9'd511, sof_pkg::EMPTY_DEPTH));
    // zero depth hides anything behind it, corner overlap included
    send_beat(make_point(20'h00200, 9'd200, 9'd200, 32'h0000_0000));
    send_beat(make_point(20'h00201, 9'd206, 9'd206, 32'h0000_0001));
    send_beat(make_point(20'h00202, 9'd212, 9'd212, 32'h0000_0001));
    send_beat(make_point(20'h00203, 9'd213, 9'd200, 32'h0000_0001));
    send_beat(make_point(20'h0F0F0, 9'd0, 9'd511, 32'h0002_0000));
    send_beat(make_point(20'hF0F0F, 9'd511, 9'd0, 32'h0002_0000));
    send_beat(make_point(20'h55555, 9'h155, 9'h0AA, 32'h8000_0000));
    send_beat(make_point(20'hAAAAA, 9'h0AA, 9'h155, 32'h7FFF_FFFF));
    // nearer point after a farther one at the same spot
    send_beat(make_point(20'h00300, 9'd300, 9'd300, 32'h0010_0000));
    send_beat(make_point(20'h00301, 9'd300, 9'd300, 32'h0000_0010));
    send_beat(make_point(20'h00302, 9'd305, 9'd300, 32'h0010_0000));
  endtask

  // clear acknowledges with id zero and empties the store
  task automatic test_clear_command();
    sof_pkg::in_item_t clr;
    send_beat(make_point(20'h00400, 9'd128, 9'd128, 32'h0000_8000));
    send_beat(make_point(20'h00401, 9'd130, 9'd128, 32'h0004_0000));
    clr          = make_point(20'hFFFFF, 9'd511, 9'd511, sof_pkg::EMPTY_DEPTH);
    clr.command  = sof_pkg::CMD_CLEAR;
    send_beat(clr);
    send_beat(make_point(20'h00402, 9'd130, 9'd128, 32'h0004_0000));
    clr          = make_point(sof_pkg::ID_W'($urandom_range(0, (1 << sof_pkg::ID_W) - 1)),
                              sof_pkg::PIX_W'($urandom_range(0, sof_pkg::PIX_MAX)),
                              sof_pkg::PIX_W'($urandom_range(0, sof_pkg::PIX_MAX)),
                              $urandom());
    clr.command  = sof_pkg::CMD_CLEAR;
    send_beat(clr);
  endtask

  // margin at both ends of the register and at one hundred percent
  task automatic test_margin_extremes();
    write_margin(7'd0);
    send_stream(120);
    write_margin(7'd127);
    send_stream(120);
    write_margin(7'd100);
    send_stream(120);
  endtask

  // random margins, a mid-stream pause, a stretch with no idling at all
  task automatic test_random_traffic();
    write_margin(sof_pkg::MARGIN_W'($urandom_range(0, 127)));
    send_stream(60);
    wait_idle();
    send_stream(60);
    write_margin(sof_pkg::MARGIN_W'($urandom_range(0, 127)));
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    send_stream(120);
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    write_margin(sof_pkg::MARGIN_RESET);
    send_stream(120);
  endtask

  // receiver holds off long enough for the filter to back up its input
  task automatic test_output_backpressure();
    write_margin(sof_pkg::MARGIN_W'($urandom_range(0, 127)));
    @(posedge clk);
    hold_cycles = HOLD_OFF_CYCLES;
    send_stream(150);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    margin_pct = sof_pkg::MARGIN_RESET;
    empty_depth_map();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_corner_cases();
    test_clear_command();
    test_margin_extremes();
    test_random_traffic();
    test_output_backpressure();

    wait_idle();
    repeat (END_WAIT_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
